// ===== rtl/assert_macros.svh =====
// assertion helpers used by the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define SSP_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("ssp assertion failed");

// consequent holds in the same cycle as the antecedent
`define SSP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssp assertion failed");

// consequent holds in the cycle after the antecedent
`define SSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssp assertion failed");

`endif

// ===== rtl/ssp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ssp_pkg;

  localparam int MAX_NODES   = 64;
  localparam int MAX_EDGES   = 256;
  localparam int WEIGHT_BITS = 16;

  // fixed field widths
  localparam int NODE_W = 6;
  localparam int CNT_W  = 7;
  localparam int IN_W_W = 16;
  localparam int DIST_W = 32;

  localparam int NODE_AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EDGE_CW = $clog2(MAX_EDGES + 1);
  localparam int EDGE_W  = 2 * NODE_W + WEIGHT_BITS;

  localparam logic [CNT_W-1:0]   NODE_CNT_RST = CNT_W'(MAX_NODES);
  localparam logic [CNT_W-1:0]   NODE_CNT_MAX = CNT_W'(MAX_NODES);
  localparam logic [EDGE_CW-1:0] EDGE_CAP     = EDGE_CW'(MAX_EDGES);

  localparam logic signed [DIST_W-1:0] DIST_UNREACH = 32'sh7FFF_FFFF;
  localparam logic signed [DIST_W:0]   SUM_HI       = 33'sh0_7FFF_FFFE;
  localparam logic signed [DIST_W:0]   SUM_LO       = 33'sh1_8000_0000;

endpackage

`default_nettype wire

// ===== rtl/ssp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ssp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/ssp_relax.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ssp_relax (
  input  wire logic                                   active_i,
  input  wire logic                                   reach_a_i,
  input  wire logic                                   reach_b_i,
  input  wire logic signed [ssp_pkg::DIST_W-1:0]      dist_a_i,
  input  wire logic signed [ssp_pkg::DIST_W-1:0]      dist_b_i,
  input  wire logic signed [ssp_pkg::WEIGHT_BITS-1:0] weight_i,
  output logic                                        update_o,
  output logic signed [ssp_pkg::DIST_W-1:0]           dist_o
);

  logic signed [ssp_pkg::DIST_W:0]   sum;
  logic signed [ssp_pkg::DIST_W-1:0] sat;

  always_comb begin
    sum = {dist_a_i[ssp_pkg::DIST_W-1], dist_a_i}
        + {{(ssp_pkg::DIST_W + 1 - ssp_pkg::WEIGHT_BITS){weight_i[ssp_pkg::WEIGHT_BITS-1]}},
           weight_i};
    // reachable distances stay one below the unreachable code
    priority if (sum > ssp_pkg::SUM_HI) begin
      sat = ssp_pkg::SUM_HI[ssp_pkg::DIST_W-1:0];
    end else if (sum < ssp_pkg::SUM_LO) begin
      sat = ssp_pkg::SUM_LO[ssp_pkg::DIST_W-1:0];
    end else begin
      sat = sum[ssp_pkg::DIST_W-1:0];
    end
  end

  assign update_o = active_i && reach_a_i && (!reach_b_i || (sat < dist_b_i));
  assign dist_o   = sat;

endmodule

`default_nettype wire

// ===== rtl/single_source_shortest_path_core.sv =====
// channel | direction | payload                                      | handshake
// edge    | in        | from_node, to_node, weight, last_edge        | in_valid_i / in_stall_o
// result  | out       | node_index, distance, edges_dropped, is_last | out_valid_o / out_stall_i
// config  | in        | node_count                                   | cfg_we_i
//
// edges load one per cycle into the edge memory while idle; the last edge starts the solve
// solve: a setup state, then a read state and a relax state per stored edge per pass
// for n-1 passes: one edge memory read and one distance read-add-compare-write per edge
// results: a read state, then a load state and a hold state per node; the hold state waits out any downstream stall
// no edge is taken from the last edge until the last result is accepted
// reset clears the edge count, the drop flag and node_count back to 64
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module single_source_shortest_path_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [ssp_pkg::CNT_W-1:0]          cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [ssp_pkg::NODE_W-1:0]         from_node_i,
  input  wire logic [ssp_pkg::NODE_W-1:0]         to_node_i,
  input  wire logic signed [ssp_pkg::IN_W_W-1:0]  weight_i,
  input  wire logic                               last_edge_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [ssp_pkg::NODE_W-1:0]              node_index_o,
  output logic signed [ssp_pkg::DIST_W-1:0]       distance_o,
  output logic                                    edges_dropped_o,
  output logic                                    is_last_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_DREAD,
    S_CALC,
    S_ORD,
    S_OLD,
    S_OHOLD
  } state_e;

  state_e state_q, state_d;

  logic [ssp_pkg::CNT_W-1:0]       node_count_q;
  logic [ssp_pkg::CNT_W-1:0]       n_q, n_d;
  logic [ssp_pkg::CNT_W-1:0]       pass_q, pass_d;
  logic [ssp_pkg::EDGE_CW-1:0]     total_q, total_d;
  logic [ssp_pkg::EDGE_CW-1:0]     k_q, k_d;
  logic                            ovf_q, ovf_d;
  logic [ssp_pkg::MAX_NODES-1:0]   reach_q, reach_d;
  logic [ssp_pkg::NODE_W-1:0]      i_q, i_d;
  logic [ssp_pkg::NODE_W-1:0]      a_q, a_d, b_q, b_d;
  logic signed [ssp_pkg::WEIGHT_BITS-1:0] w_q, w_d;
  logic                            act_q, act_d;

  logic                            out_valid_q, out_valid_d;
  logic [ssp_pkg::NODE_W-1:0]      node_index_q, node_index_d;
  logic signed [ssp_pkg::DIST_W-1:0] distance_q, distance_d;
  logic                            dropped_q, dropped_d;
  logic                            is_last_q, is_last_d;

  logic                            in_acc, out_acc;
  logic [ssp_pkg::CNT_W-1:0]       n_eff;

  logic                            edge_we;
  logic [ssp_pkg::EDGE_W-1:0]      edge_wdata, edge_rdata;
  logic [ssp_pkg::NODE_W-1:0]      e_from, e_to;
  logic signed [ssp_pkg::WEIGHT_BITS-1:0] e_w;

  logic                            dist_we;
  logic [ssp_pkg::NODE_AW-1:0]     dist_waddr, dist_raddr_a;
  logic signed [ssp_pkg::DIST_W-1:0] dist_wdata, dist_a, dist_b;

  logic                            relax_upd;
  logic signed [ssp_pkg::DIST_W-1:0] relax_dist;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_q && !out_stall_i;

  always_comb begin
    priority if (node_count_q == '0) begin
      n_eff = ssp_pkg::CNT_W'(1);
    end else if (node_count_q > ssp_pkg::NODE_CNT_MAX) begin
      n_eff = ssp_pkg::NODE_CNT_MAX;
    end else begin
      n_eff = node_count_q;
    end
  end

  assign e_from = edge_rdata[ssp_pkg::EDGE_W-1 -: ssp_pkg::NODE_W];
  assign e_to   = edge_rdata[ssp_pkg::WEIGHT_BITS +: ssp_pkg::NODE_W];
  assign e_w    = edge_rdata[ssp_pkg::WEIGHT_BITS-1:0];

  assign edge_we    = in_acc && (total_q < ssp_pkg::EDGE_CAP);
  assign edge_wdata = {from_node_i, to_node_i, weight_i[ssp_pkg::WEIGHT_BITS-1:0]};

  ssp_ram #(
    .WIDTH(ssp_pkg::EDGE_W),
    .DEPTH(ssp_pkg::MAX_EDGES)
  ) u_edge_ram (
    .clk_i  (clk_i),
    .we_i   (edge_we),
    .waddr_i(total_q[ssp_pkg::EDGE_AW-1:0]),
    .wdata_i(edge_wdata),
    .raddr_i(k_d[ssp_pkg::EDGE_AW-1:0]),
    .rdata_o(edge_rdata)
  );

  // two copies of the distances give a read at the tail and the head per cycle
  assign dist_raddr_a = (state_q == S_DREAD) ? e_from[ssp_pkg::NODE_AW-1:0]
                                             : i_d[ssp_pkg::NODE_AW-1:0];
  assign dist_we    = (state_q == S_START) || ((state_q == S_CALC) && relax_upd);
  assign dist_waddr = (state_q == S_START) ? '0 : b_q[ssp_pkg::NODE_AW-1:0];
  assign dist_wdata = (state_q == S_START) ? '0 : relax_dist;

  ssp_ram #(
    .WIDTH(ssp_pkg::DIST_W),
    .DEPTH(ssp_pkg::MAX_NODES)
  ) u_dist_ram_a (
    .clk_i  (clk_i),
    .we_i   (dist_we),
    .waddr_i(dist_waddr),
    .wdata_i(dist_wdata),
    .raddr_i(dist_raddr_a),
    .rdata_o(dist_a)
  );

  ssp_ram #(
    .WIDTH(ssp_pkg::DIST_W),
    .DEPTH(ssp_pkg::MAX_NODES)
  ) u_dist_ram_b (
    .clk_i  (clk_i),
    .we_i   (dist_we),
    .waddr_i(dist_waddr),
    .wdata_i(dist_wdata),
    .raddr_i(e_to[ssp_pkg::NODE_AW-1:0]),
    .rdata_o(dist_b)
  );

  ssp_relax u_relax (
    .active_i (act_q),
    .reach_a_i(reach_q[a_q[ssp_pkg::NODE_AW-1:0]]),
    .reach_b_i(reach_q[b_q[ssp_pkg::NODE_AW-1:0]]),
    .dist_a_i (dist_a),
    .dist_b_i (dist_b),
    .weight_i (w_q),
    .update_o (relax_upd),
    .dist_o   (relax_dist)
  );

  always_comb begin
    state_d      = state_q;
    n_d          = n_q;
    pass_d       = pass_q;
    total_d      = total_q;
    k_d          = k_q;
    ovf_d        = ovf_q;
    reach_d      = reach_q;
    i_d          = i_q;
    a_d          = a_q;
    b_d          = b_q;
    w_d          = w_q;
    act_d        = act_q;
    out_valid_d  = out_valid_q;
    node_index_d = node_index_q;
    distance_d   = distance_q;
    dropped_d    = dropped_q;
    is_last_d    = is_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (total_q < ssp_pkg::EDGE_CAP) begin
            total_d = total_q + ssp_pkg::EDGE_CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_edge_i) begin
            state_d = S_START;
          end
        end
      end
      S_START: begin
        n_d        = n_eff;
        reach_d    = '0;
        reach_d[0] = 1'b1;
        pass_d     = ssp_pkg::CNT_W'(1);
        k_d        = '0;
        i_d        = '0;
        if ((n_eff == ssp_pkg::CNT_W'(1)) || (total_q == '0)) begin
          state_d = S_ORD;
        end else begin
          state_d = S_DREAD;
        end
      end
      S_DREAD: begin
        a_d     = e_from;
        b_d     = e_to;
        w_d     = e_w;
        act_d   = (ssp_pkg::CNT_W'(e_from) < n_q) && (ssp_pkg::CNT_W'(e_to) < n_q);
        state_d = S_CALC;
      end
      S_CALC: begin
        if (relax_upd) begin
          reach_d[b_q[ssp_pkg::NODE_AW-1:0]] = 1'b1;
        end
        if (k_q + ssp_pkg::EDGE_CW'(1) == total_q) begin
          k_d = '0;
          if (pass_q + ssp_pkg::CNT_W'(1) == n_q) begin
            state_d = S_ORD;
          end else begin
            pass_d  = pass_q + ssp_pkg::CNT_W'(1);
            state_d = S_DREAD;
          end
        end else begin
          k_d     = k_q + ssp_pkg::EDGE_CW'(1);
          state_d = S_DREAD;
        end
      end
      S_ORD: begin
        state_d = S_OLD;
      end
      S_OLD: begin
        out_valid_d  = 1'b1;
        node_index_d = i_q;
        distance_d   = reach_q[i_q[ssp_pkg::NODE_AW-1:0]] ? dist_a : ssp_pkg::DIST_UNREACH;
        dropped_d    = ovf_q;
        is_last_d    = (ssp_pkg::CNT_W'(i_q) + ssp_pkg::CNT_W'(1)) == n_q;
        state_d      = S_OHOLD;
      end
      S_OHOLD: begin
        if (out_acc) begin
          out_valid_d = 1'b0;
          if (is_last_q) begin
            total_d = '0;
            ovf_d   = 1'b0;
            state_d = S_IDLE;
          end else begin
            // next node address goes to the distance memory in this cycle
            i_d     = i_q + ssp_pkg::NODE_W'(1);
            state_d = S_OLD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      node_count_q <= ssp_pkg::NODE_CNT_RST;
      total_q      <= '0;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      reach_q      <= '0;
      n_q          <= ssp_pkg::NODE_CNT_RST;
      pass_q       <= '0;
      k_q          <= '0;
      i_q          <= '0;
      act_q        <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      total_q      <= total_d;
      ovf_q        <= ovf_d;
      out_valid_q  <= out_valid_d;
      reach_q      <= reach_d;
      n_q          <= n_d;
      pass_q       <= pass_d;
      k_q          <= k_d;
      i_q          <= i_d;
      act_q        <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q          <= a_d;
    b_q          <= b_d;
    w_q          <= w_d;
    node_index_q <= node_index_d;
    distance_q   <= distance_d;
    dropped_q    <= dropped_d;
    is_last_q    <= is_last_d;
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign node_index_o    = node_index_q;
  assign distance_o      = distance_q;
  assign edges_dropped_o = dropped_q;
  assign is_last_o       = is_last_q;

  `SSP_ASSERT_SAME(a_no_load_while_out, clk_i, rst_ni, in_acc, !out_valid_q)
  `SSP_ASSERT_SAME(a_source_reached, clk_i, rst_ni, state_q == S_CALC, reach_q[0])
  `SSP_ASSERT_NEXT(a_clear_after_last, clk_i, rst_ni, out_acc && is_last_q,
                   (total_q == '0) && !ovf_q && (state_q == S_IDLE))
  `SSP_ASSERT_ALWAYS(a_index_in_range, clk_i, rst_ni,
                     !out_valid_q || (ssp_pkg::CNT_W'(node_index_q) < n_q))
  `SSP_ASSERT_ALWAYS(a_total_bound, clk_i, rst_ni, total_q <= ssp_pkg::EDGE_CAP)

endmodule

`default_nettype wire

// ===== bench/ssp_checker.sv =====
`timescale 1ns / 1ps

module ssp_checker
  import ssp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CNT_W-1:0]         cfg_wdata_i,
  input  logic                     in_valid_i,
  input  logic                     in_stall_o,
  input  logic [NODE_W-1:0]        from_node_i,
  input  logic [NODE_W-1:0]        to_node_i,
  input  logic signed [IN_W_W-1:0] weight_i,
  input  logic                     last_edge_i,
  input  logic                     out_valid_o,
  input  logic                     out_stall_i,
  input  logic [NODE_W-1:0]        node_index_o,
  input  logic signed [DIST_W-1:0] distance_o,
  input  logic                     edges_dropped_o,
  input  logic                     is_last_o,
  output int                       failures,
  output int                       pending
);

  typedef struct {
    logic [NODE_W-1:0]             tail;
    logic [NODE_W-1:0]             head;
    logic signed [WEIGHT_BITS-1:0] weight;
  } graph_edge_t;

  typedef struct {
    logic [NODE_W-1:0]        node;
    logic signed [DIST_W-1:0] path_len;
    logic                     dropped;
    logic                     final_node;
  } node_dist_t;

  graph_edge_t       graph_edges[$];
  node_dist_t        dist_expected[$];
  logic [CNT_W-1:0]  node_count_q;
  logic              store_overflow;
  int                err_count;

  // relax every stored edge in arrival order, n-1 passes, then queue one distance per node
  function automatic void solve_graph();
    int unsigned n;
    int unsigned a;
    int unsigned b;
    longint      node_dist[MAX_NODES];
    bit          reach[MAX_NODES];
    longint      sum;
    node_dist_t  r;
    if (node_count_q == '0) n = 1;
    else if (node_count_q > NODE_CNT_MAX) n = MAX_NODES;
    else n = node_count_q;
    foreach (node_dist[i]) begin
      node_dist[i] = 0;
      reach[i]     = 1'b0;
    end
    reach[0] = 1'b1;
    for (int p = 1; p < n; p++) begin
      foreach (graph_edges[k]) begin
        a = graph_edges[k].tail;
        b = graph_edges[k].head;
        if (a < n && b < n && reach[a]) begin
          sum = node_dist[a] + longint'(graph_edges[k].weight);
          if (sum > longint'(SUM_HI)) sum = longint'(SUM_HI);
          if (sum < longint'(SUM_LO)) sum = longint'(SUM_LO);
          if (!reach[b] || sum < node_dist[b]) begin
            node_dist[b] = sum;
            reach[b]     = 1'b1;
          end
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      r.node       = NODE_W'(i);
      r.path_len   = reach[i] ? node_dist[i][DIST_W-1:0] : DIST_UNREACH;
      r.dropped    = store_overflow;
      r.final_node = (i == n - 1);
      dist_expected.insert(dist_expected.size(), r);
    end
    graph_edges.delete();
    store_overflow = 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    graph_edge_t e;
    node_dist_t  want;
    if (!rst_ni) begin
      graph_edges.delete();
      dist_expected.delete();
      node_count_q   = NODE_CNT_RST;
      store_overflow = 1'b0;
      err_count      = 0;
      failures      <= 0;
      pending       <= 0;
    end else begin
      if (cfg_we_i) node_count_q = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) begin
        e.tail   = from_node_i;
        e.head   = to_node_i;
        e.weight = weight_i[WEIGHT_BITS-1:0];
        if (graph_edges.size() < MAX_EDGES) graph_edges.insert(graph_edges.size(), e);
        else store_overflow = 1'b1;
        if (last_edge_i) solve_graph();
      end
      if (out_valid_o && !out_stall_i) begin
        if (dist_expected.size() == 0) begin
          $error("result for node %0d with nothing expected", node_index_o);
          err_count++;
        end else begin
          want = dist_expected.pop_front();
          if (node_index_o !== want.node) begin
            $error("node_index: expected %0d, got %0d", want.node, node_index_o);
            err_count++;
          end
          if (distance_o !== want.path_len) begin
            $error("distance: expected %0d, got %0d", want.path_len, distance_o);
            err_count++;
          end
          if (edges_dropped_o !== want.dropped) begin
            $error("edges_dropped: expected %0d, got %0d", want.dropped, edges_dropped_o);
            err_count++;
          end
          if (is_last_o !== want.final_node) begin
            $error("is_last: expected %0d, got %0d", want.final_node, is_last_o);
            err_count++;
          end
        end
      end
      failures <= err_count;
      pending  <= dist_expected.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import ssp_pkg::*;

  localparam int RANDOM_ITEMS = 30;
  localparam int QUIET_LIMIT  = 200000;

  logic                     clk_i;
  logic                     rst_ni       = 1'b0;
  logic                     cfg_we_i     = 1'b0;
  logic [CNT_W-1:0]         cfg_wdata_i  = '0;
  logic                     in_valid_i   = 1'b0;
  logic                     in_stall_o;
  logic [NODE_W-1:0]        from_node_i  = '0;
  logic [NODE_W-1:0]        to_node_i    = '0;
  logic signed [IN_W_W-1:0] weight_i     = '0;
  logic                     last_edge_i  = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i  = 1'b0;
  logic [NODE_W-1:0]        node_index_o;
  logic signed [DIST_W-1:0] distance_o;
  logic                     edges_dropped_o;
  logic                     is_last_o;

  int          failures;
  int          pending;
  int          edges_sent   = 0;
  int unsigned node_span    = MAX_NODES;
  bit          src_idle     = 1'b0;
  bit          sink_idle    = 1'b0;
  int unsigned stall_left   = 0;
  int unsigned quiet_cycles = 0;

  single_source_shortest_path_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .from_node_i    (from_node_i),
    .to_node_i      (to_node_i),
    .weight_i       (weight_i),
    .last_edge_i    (last_edge_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .node_index_o   (node_index_o),
    .distance_o     (distance_o),
    .edges_dropped_o(edges_dropped_o),
    .is_last_o      (is_last_o)
  );

  ssp_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .from_node_i    (from_node_i),
    .to_node_i      (to_node_i),
    .weight_i       (weight_i),
    .last_edge_i    (last_edge_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .node_index_o   (node_index_o),
    .distance_o     (distance_o),
    .edges_dropped_o(edges_dropped_o),
    .is_last_o      (is_last_o),
    .failures       (failures),
    .pending        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // result side back-pressure in random bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (sink_idle && $urandom_range(0, 4) == 0) begin
      stall_left  <= $urandom_range(0, 6);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a clock edge; returns at the edge where the request was taken
  task automatic send_edge(input logic [NODE_W-1:0] tail, input logic [NODE_W-1:0] head,
                           input logic signed [IN_W_W-1:0] w, input logic last);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    from_node_i <= tail;
    to_node_i   <= head;
    weight_i    <= w;
    last_edge_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    edges_sent++;
  endtask

  // drain all results, let the core settle, then write node_count
  task automatic set_node_count(input logic [CNT_W-1:0] value);
    in_valid_i <= 1'b0;
    // the count of outstanding results is registered, so let it settle after the last request
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (value == '0) node_span = 1;
    else if (value > NODE_CNT_MAX) node_span = MAX_NODES;
    else node_span = value;
  endtask

  // mostly in range, sometimes anywhere in the 6-bit field
  function automatic logic [NODE_W-1:0] pick_node();
    if ($urandom_range(0, 9) == 0) return NODE_W'($urandom_range(0, 63));
    return NODE_W'($urandom_range(0, node_span - 1));
  endfunction

  function automatic logic signed [IN_W_W-1:0] pick_weight();
    case ($urandom_range(0, 9))
      0, 1:    return IN_W_W'($urandom);
      2:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      3, 4:    return IN_W_W'(int'($urandom_range(0, 2000)) - 1000);
      default: return IN_W_W'(int'($urandom_range(0, 60)) - 20);
    endcase
  endfunction

  task automatic random_graph(input int count);
    for (int k = 0; k < count; k++) send_edge(pick_node(), pick_node(), pick_weight(),
                                               k == count - 1);
  endtask

  initial begin
    int               random_start;
    int               phase_end;
    logic [CNT_W-1:0] phase_counts[6];
    phase_counts = '{7'd4, 7'd1, 7'd64, 7'd2, 7'd0, 7'd100};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset node count of 64, single heavy edge
    send_edge(6'd0, 6'd1, 16'sh7FFF, 1'b1);

    // zero acts as one node: no passes, only the source reported
    set_node_count(7'd0);
    send_edge(6'd0, 6'd0, 16'sh8000, 1'b1);

    // above the maximum acts as 64
    set_node_count(7'd127);
    send_edge(6'd0, 6'd63, 16'sh8000, 1'b0);
    send_edge(6'd63, 6'd62, 16'sh8000, 1'b1);

    // negative cycle, unreachable island, endpoints out of range
    set_node_count(7'd5);
    send_edge(6'd0, 6'd1, 16'sd10, 1'b0);
    send_edge(6'd1, 6'd2, -16'sd3, 1'b0);
    send_edge(6'd2, 6'd1, 16'sd1, 1'b0);
    send_edge(6'd3, 6'd4, 16'sd7, 1'b0);
    send_edge(6'd7, 6'd2, -16'sd100, 1'b0);
    send_edge(6'd1, 6'd9, 16'sd5, 1'b0);
    send_edge(6'd4, 6'd4, -16'sd1, 1'b1);

    // back-to-back graphs with no pause
    set_node_count(7'd2);
    send_edge(6'd1, 6'd0, 16'sd5, 1'b1);
    send_edge(6'd0, 6'd1, -16'sd1, 1'b1);

    // store filled exactly, then overflow; the dropped last edge still starts the solve
    set_node_count(7'd64);
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    for (int k = 0; k < MAX_EDGES + 2; k++) send_edge(pick_node(), pick_node(), pick_weight(),
                                                      k == MAX_EDGES + 1);

    random_start = edges_sent;
    for (int p = 0; p < 6 || edges_sent - random_start < RANDOM_ITEMS; p++) begin
      if (p < 6) set_node_count(phase_counts[p]);
      else set_node_count(CNT_W'($urandom_range(1, 16)));
      phase_end = edges_sent + 4;
      while (edges_sent < phase_end) begin
        // final stretch runs without idling on either side
        if (edges_sent - random_start > RANDOM_ITEMS - 12) begin
          src_idle  = 1'b0;
          sink_idle = 1'b0;
        end else begin
          src_idle  = $urandom_range(0, 2) != 0;
          sink_idle = $urandom_range(0, 2) != 0;
        end
        random_graph($urandom_range(1, 5));
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (failures == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
